// ----- rtl/ibm_ieee_float_converter_macros.svh -----
// assertion macros shared by the converter rtl
`ifndef IBM_IEEE_FLOAT_CONVERTER_MACROS_SVH
`define IBM_IEEE_FLOAT_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define IBF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ibf_pkg.sv -----
// types, constants and helpers shared by the converter stages
`timescale 1ns / 1ps
`default_nettype none
package ibf_pkg;

    localparam int WORD_W = 32;
    localparam int EXP_W  = 10;   // signed working exponent
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TO_IBM_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES       = 1'b1;

    localparam logic signed [EXP_W-1:0] IBM_EXP_ADJ  = 10'sd130;
    localparam logic signed [EXP_W-1:0] IEEE_EXP_MAX = 10'sd254;
    localparam logic [8:0]              IEEE_TO_IBM_ADJ = 9'd130;
    localparam logic [30:0]             IEEE_MAX_MAG = 31'h7f7fffff;
    localparam logic [30:0]             IBM_MAX_MAG  = 31'h7fffffff;
    localparam logic [7:0]              IEEE_EXP_SPECIAL = 8'hff;

    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_ZERO,
        CLS_SIGNED_ZERO,
        CLS_SATURATE
    } cls_t;

    typedef struct packed {
        logic                    to_ibm;
        logic                    swap;
        cls_t                    cls;
        logic                    sign;
        logic signed [EXP_W-1:0] expo;
        logic [WORD_W-1:0]       mant;
        logic                    last;
    } ibf_item_t;

    function automatic logic [WORD_W-1:0] rev_bytes(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ibm_ieee_float_converter.sv -----
// top level of the ibm hex float / ieee-754 single word converter
`timescale 1ns / 1ps
`default_nettype none
// Converts one 32-bit word per accepted input word, either from IBM System/360
// hexadecimal single (sign, excess-64 base-16 exponent, 24-bit fraction) to
// IEEE-754 single or the other way round, set by register 0 (to_ibm_direction,
// reset 0 = ibm to ieee). Register 1 (swap_bytes, reset 1) reverses the byte
// order of the ibm-side word: on the input when going to ieee, on the output
// when going to ibm. Fractions are truncated. Ibm zero fractions and exponent
// underflow give +0, exponent overflow saturates to the largest finite ieee
// value; ieee inf and nan give the largest ibm magnitude and denormals are
// renormalized. The datapath is a three-stage pipeline (decode, normalize,
// pack), each stage registered, and one word per cycle streams through; a
// stalled output holds every stage in place. Write the registers only while
// no word is in flight. last_in rides along with its word unchanged.
module ibm_ieee_float_converter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [ibf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ibf_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ibf_pkg::WORD_W-1:0]     s_word_in,
    input  wire logic                           s_last_in,
    // result words
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ibf_pkg::WORD_W-1:0]          m_word_out,
    output logic                                m_last_out
);
    import ibf_pkg::*;

    // configuration registers
    logic      to_ibm_direction_reg;
    logic      swap_bytes_reg;

    // stage handshakes and payloads
    logic      s1_valid;
    logic      s1_ready;
    ibf_item_t s1_item;
    logic      s2_valid;
    logic      s2_ready;
    ibf_item_t s2_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to_ibm_direction_reg <= 1'b0;
            swap_bytes_reg       <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TO_IBM_DIRECTION: to_ibm_direction_reg <= cfg_data[0];
                CFG_SWAP_BYTES:       swap_bytes_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: swap input word, classify, rebias exponent
    ibf_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .to_ibm    (to_ibm_direction_reg),
        .swap      (swap_bytes_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_word_in),
        .in_last   (s_last_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_item  (s1_item)
    );

    // stage 2: leading-zero count (bits or hex digits) and shift
    ibf_normalize u_normalize (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_item   (s1_item),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_item  (s2_item)
    );

    // stage 3: range checks, pack fields, output swap; holds the result word
    ibf_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_item   (s2_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word_out),
        .out_last  (m_last_out)
    );

`include "ibm_ieee_float_converter_macros.svh"

    // every accepted word shows up in the first stage
`IBF_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, s1_valid, "accepted word not in first stage")

endmodule
`default_nettype wire

// ----- rtl/ibf_decode.sv -----
// first stage: byte swap, special-case classification, exponent rebias
`timescale 1ns / 1ps
`default_nettype none
module ibf_decode (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      to_ibm,
    input  wire logic                      swap,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ibf_pkg::WORD_W-1:0] in_word,
    input  wire logic                      in_last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output ibf_pkg::ibf_item_t             out_item
);
    import ibf_pkg::*;

    logic              valid_reg;
    ibf_item_t         item_reg;
    ibf_item_t         item_next;
    logic [WORD_W-1:0] w_ibm;
    logic [7:0]        ex;
    logic [8:0]        ex9;
    logic [8:0]        ex9_rnd;
    logic [1:0]        sh;
    logic [WORD_W-1:0] fr;

    assign w_ibm   = swap ? rev_bytes(in_word) : in_word;
    assign ex      = in_word[30:23];
    assign ex9     = {1'b0, ex} + IEEE_TO_IBM_ADJ;
    assign ex9_rnd = ex9 + 9'd3;
    // align to a hex-digit boundary
    assign sh      = 2'd0 - ex9[1:0];
    assign fr      = (ex != 8'd0) ? {1'b1, in_word[22:0], 8'd0} : {in_word[22:0], 9'd0};

    always_comb begin
        item_next        = '0;
        item_next.to_ibm = to_ibm;
        item_next.swap   = swap;
        item_next.last   = in_last;
        if (to_ibm) begin
            item_next.sign = in_word[31];
            item_next.mant = fr >> sh;
            item_next.expo = EXP_W'(ex9_rnd[8:2]);
            if (ex == IEEE_EXP_SPECIAL) begin
                item_next.cls = CLS_SATURATE;
            end else if (in_word[30:0] == 31'd0) begin
                item_next.cls = CLS_SIGNED_ZERO;
            end else begin
                item_next.cls = CLS_NORMAL;
            end
        end else begin
            item_next.sign = w_ibm[31];
            item_next.mant = {w_ibm[23:0], 8'd0};
            item_next.expo = $signed({1'b0, w_ibm[30:24], 2'b00}) - IBM_EXP_ADJ;
            item_next.cls  = (w_ibm[23:0] == 24'd0) ? CLS_ZERO : CLS_NORMAL;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- rtl/ibf_normalize.sv -----
// second stage: leading-zero count and normalizing shift
`timescale 1ns / 1ps
`default_nettype none
module ibf_normalize (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ibf_pkg::ibf_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ibf_pkg::ibf_item_t      out_item
);
    import ibf_pkg::*;

    // leading zero bit count, 24 when the fraction is empty
    function automatic logic [4:0] lz24(input logic [23:0] f);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (f[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    // leading zero hex digits, at most seven
    function automatic logic [2:0] lz_hex(input logic [WORD_W-1:0] f);
        logic [2:0] n;
        logic       hit;
        n   = 3'd0;
        hit = 1'b0;
        for (int i = 7; i > 0; i--) begin
            if (!hit && f[4*i +: 4] == 4'd0) begin
                n = n + 3'd1;
            end else begin
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    logic       valid_reg;
    ibf_item_t  item_reg;
    ibf_item_t  item_next;
    logic [4:0] lz_bits;
    logic [2:0] lz_digits;
    logic [4:0] amt;
    logic [4:0] exp_dec;

    assign lz_bits   = lz24(in_item.mant[31:8]);
    assign lz_digits = lz_hex(in_item.mant);
    assign amt       = in_item.to_ibm ? {lz_digits, 2'b00} : lz_bits;
    assign exp_dec   = in_item.to_ibm ? {2'b00, lz_digits} : lz_bits;

    always_comb begin
        item_next      = in_item;
        item_next.mant = in_item.mant << amt;
        item_next.expo = in_item.expo - $signed({{(EXP_W-5){1'b0}}, exp_dec});
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- rtl/ibf_pack.sv -----
// third stage: range checks, packing and output byte swap
`timescale 1ns / 1ps
`default_nettype none
module ibf_pack (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire ibf_pkg::ibf_item_t        in_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [ibf_pkg::WORD_W-1:0]     out_word,
    output logic                           out_last
);
    import ibf_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic              dir_reg;
    logic              swap_reg;
    logic [WORD_W-1:0] ieee_word;
    logic [WORD_W-1:0] ibm_word;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        ieee_word = '0;
        if (in_item.cls == CLS_ZERO) begin
            ieee_word = '0;
        end else if (in_item.expo > IEEE_EXP_MAX) begin
            ieee_word = {in_item.sign, IEEE_MAX_MAG};
        end else if (in_item.expo <= $signed(EXP_W'(0))) begin
            ieee_word = '0;
        end else begin
            ieee_word = {in_item.sign, in_item.expo[7:0], in_item.mant[30:8]};
        end
    end

    always_comb begin
        unique case (in_item.cls)
            CLS_SATURATE:    ibm_word = {in_item.sign, IBM_MAX_MAG};
            CLS_SIGNED_ZERO: ibm_word = {in_item.sign, 31'd0};
            CLS_ZERO:        ibm_word = '0;
            CLS_NORMAL:      ibm_word = {in_item.sign, in_item.expo[6:0], in_item.mant[31:8]};
            default:         ibm_word = '0;
        endcase
    end

    assign word_next = in_item.to_ibm ? (in_item.swap ? rev_bytes(ibm_word) : ibm_word)
                                      : ieee_word;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
            last_reg <= in_item.last;
            dir_reg  <= in_item.to_ibm;
            swap_reg <= in_item.swap;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_last  = last_reg;

`include "ibm_ieee_float_converter_macros.svh"

    // ieee results are finite
`IBF_ASSERT_IMPL(a_ieee_finite, valid_reg && !dir_reg, word_reg[30:23] != IEEE_EXP_SPECIAL, "ieee result is inf or nan")
    // no denormals are produced
`IBF_ASSERT_IMPL(a_ieee_no_denorm, valid_reg && !dir_reg && (word_reg[30:23] == 8'd0), word_reg == '0, "ieee result is denormal or signed zero")
    // ibm fractions leave with a nonzero leading digit
`IBF_ASSERT_IMPL(a_ibm_normal, valid_reg && dir_reg && !swap_reg && (word_reg[23:0] != 24'd0), word_reg[23:20] != 4'd0, "ibm result not normalized")

endmodule
`default_nettype wire

// ----- tb/ibm_ieee_float_converter_tb.sv -----
// self-checking testbench for the ibm hex float / ieee-754 single word converter
`timescale 1ns / 1ps
module ibm_ieee_float_converter_tb;

    import ibf_pkg::*;

    // pipeline is three stages deep; leave some margin before register writes
    localparam int DRAIN_TAIL  = 8;
    // cycles with no word moving on either side before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    localparam int GAP_MAX     = 16;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } conv_word_t;

    logic                  aclk;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_TO_IBM_DIRECTION;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_word_in  = '0;
    logic                  s_last_in  = 1'b0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [WORD_W-1:0]     m_word_out;
    logic                  m_last_out;

    // shadow copy of the two registers, reset values of the block
    logic cur_to_ibm = 1'b0;
    logic cur_swap   = 1'b1;

    // converted words still owed by the block, oldest first
    conv_word_t pending[$];

    int  n_errors     = 0;
    int  quiet_cycles = 0;
    int  rx_wait      = 0;
    // burst flags turn the random gaps off for a stretch
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;

    ibm_ieee_float_converter DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word_in  (s_word_in),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word_out (m_word_out),
        .m_last_out (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // conversion predictor
    // ---------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] flip_bytes(input logic [WORD_W-1:0] w);
        return {<<8{w}};
    endfunction

    // ibm hex float to ieee single, truncating, saturating on overflow
    function automatic logic [WORD_W-1:0] hex_to_ieee(input logic [WORD_W-1:0] w);
        logic [23:0] frac;
        int          e;
        int          lz;
        frac = w[23:0];
        // zero fraction covers true zero and any sign/exponent with no digits
        if (frac == 24'd0)
            return '0;
        e = int'(w[30:24]);
        e = 4 * e - 130;
        lz = 0;
        while (lz < 24 && !frac[23]) begin
            frac = frac << 1;
            lz++;
        end
        e = e - lz;
        if (e > 254)
            return {w[31], 31'h7f7fffff};
        // underflow flushes to +0, no denormals
        if (e <= 0)
            return '0;
        return {w[31], e[7:0], frac[22:0]};
    endfunction

    // ieee single to ibm hex float, denormals renormalized by hex digits
    function automatic logic [WORD_W-1:0] ieee_to_hex(input logic [WORD_W-1:0] w);
        logic [31:0] fr;
        int unsigned ex;
        int unsigned sh;
        int unsigned digits;
        fr = {w[22:0], 9'd0};
        ex = 32'(w[30:23]);
        if (w == '0)
            return '0;
        // inf and nan both go to the largest ibm magnitude
        if (ex == 255)
            return {w[31], 31'h7fffffff};
        if (ex > 0)
            fr = {1'b1, fr[31:1]};
        else if (fr == '0)
            return {w[31], 31'd0};
        ex = ex + 130;
        sh = (4 - (ex % 4)) % 4;
        fr = fr >> sh;
        ex = (ex + 3) / 4;
        digits = 0;
        while (fr < 32'h10000000 && digits < 8 && ex > 0) begin
            ex--;
            fr = fr << 4;
            digits++;
        end
        return {w[31], ex[6:0], fr[31:8]};
    endfunction

    function automatic logic [WORD_W-1:0] convert_word(input logic [WORD_W-1:0] w);
        if (cur_to_ibm)
            return cur_swap ? flip_bytes(ieee_to_hex(w)) : ieee_to_hex(w);
        return hex_to_ieee(cur_swap ? flip_bytes(w) : w);
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // ---------------------------------------------------------------------
    // result side: random back-pressure and in-order compare
    // ---------------------------------------------------------------------

    always @(posedge aclk) begin
        conv_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else if (m_valid && m_ready) begin
            if (pending.size() == 0) begin
                $error("word_out: no word expected, got %h", m_word_out);
                n_errors++;
            end else begin
                want = pending.pop_front();
                if (m_word_out !== want.word) begin
                    $error("word_out: expected %h, got %h", want.word, m_word_out);
                    n_errors++;
                end
                if (m_last_out !== want.last) begin
                    $error("last_out: expected %b, got %b", want.last, m_last_out);
                    n_errors++;
                end
            end
            if ($urandom_range(0, 24) == 0)
                rx_burst = !rx_burst;
            rx_wait = draw_gap(rx_burst);
            m_ready <= (rx_wait == 0);
        end else if (!m_ready) begin
            if (rx_wait > 0)
                rx_wait--;
            if (rx_wait == 0)
                m_ready <= 1'b1;
        end
    end

    // hang detector: counts cycles in which no word moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------

    // offers one word after a random gap and books its converted value once taken
    task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
        int         gap;
        conv_word_t want;
        if ($urandom_range(0, 24) == 0)
            tx_burst = !tx_burst;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_word_in <= w;
        s_last_in <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want.word = convert_word(w);
        want.last = last;
        pending.push_back(want);
    endtask

    // stop offering words until every converted word has come back
    task automatic wait_empty();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending.size() != 0);
    endtask

    // registers only change with the pipeline empty
    task automatic set_mode(input logic to_ibm, input logic swap);
        wait_empty();
        repeat (DRAIN_TAIL) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TO_IBM_DIRECTION;
        cfg_data  <= to_ibm;
        @(posedge aclk);
        cur_to_ibm = to_ibm;
        cfg_index <= CFG_SWAP_BYTES;
        cfg_data  <= swap;
        @(posedge aclk);
        cur_swap = swap;
        cfg_wr_en <= 1'b0;
    endtask

    // ibm words biased toward the interesting corners of the conversion
    function automatic logic [WORD_W-1:0] rand_ibm_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            3: r[23:0] = '0;                                   // digits all zero
            4: begin                                           // exponent near the edges
                case ($urandom_range(0, 2))
                    0: r[30:24] = 7'($urandom_range(28, 36));
                    1: r[30:24] = 7'($urandom_range(94, 100));
                    default: r[30:24] = $urandom_range(0, 1) ? 7'h7f : 7'h00;
                endcase
            end
            5: r[23:0] = 24'(r >> $urandom_range(8, 31));      // leading zero digits
            6: r = {r[31], 31'd0};                             // plus and minus zero
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_ieee_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            3: begin                                           // inf and nan
                r[30:23] = 8'hff;
                if ($urandom_range(0, 1))
                    r[22:0] = '0;
            end
            4: begin                                           // denormals
                r[30:23] = 8'h00;
                r[22:0]  = 23'(r >> $urandom_range(9, 31));
            end
            5: r = {r[31], 31'd0};
            6: r[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(1, 8))
                                               : 8'($urandom_range(247, 254));
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset values: ibm to ieee with byte-swapped input
    task automatic test_reset_defaults();
        send_word(flip_bytes(32'h41100000), 1'b0);   // 1.0
        send_word(flip_bytes(32'hc2640000), 1'b0);   // -100.0
        send_word(32'h00000000, 1'b1);
    endtask

    task automatic test_ibm_special_cases();
        set_mode(1'b0, 1'b0);
        send_word(32'h00000000, 1'b0);
        send_word(32'h80000000, 1'b1);   // negative zero
        send_word(32'h41000000, 1'b0);   // exponent without digits
        send_word(32'hc5000000, 1'b0);
        send_word(32'h7fffffff, 1'b1);   // overflow, positive
        send_word(32'hffffffff, 1'b0);   // overflow, negative
        send_word(32'h00ffffff, 1'b0);   // underflow
        send_word(32'h20100000, 1'b0);   // underflow after normalization
        send_word(32'h41100000, 1'b1);
        send_word(32'h40000001, 1'b0);   // long leading-zero shift
    endtask

    task automatic test_ieee_special_cases();
        set_mode(1'b1, 1'b0);
        send_word(32'h00000000, 1'b0);
        send_word(32'h80000000, 1'b1);   // negative zero keeps its sign
        send_word(32'h7f800000, 1'b0);   // +inf
        send_word(32'hff800000, 1'b0);   // -inf
        send_word(32'h7fc00001, 1'b1);   // nan
        send_word(32'h00000001, 1'b0);   // smallest denormal
        send_word(32'h807fffff, 1'b0);   // largest denormal, negative
        send_word(32'h00800000, 1'b0);   // smallest normal
        send_word(32'h3f800000, 1'b1);
        send_word(32'h7f7fffff, 1'b0);   // largest finite
    endtask

    task automatic test_random_stream(input logic to_ibm, input logic swap, input int n);
        logic [WORD_W-1:0] w;
        set_mode(to_ibm, swap);
        repeat (n) begin
            w = to_ibm ? rand_ieee_word() : rand_ibm_word();
            // mostly present the ibm word in host order so the swap lands on real shapes
            if (!to_ibm && swap && $urandom_range(0, 3) != 0)
                w = flip_bytes(w);
            send_word(w, $urandom_range(0, 7) == 0);
        end
    endtask

    // sender holds off mid-stream until the block has handed everything back
    task automatic test_stall_until_empty();
        repeat (24) send_word(rand_ibm_word(), 1'($urandom_range(0, 1)));
        wait_empty();
        repeat (24) send_word(rand_ibm_word(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_ibm_special_cases();
        test_ieee_special_cases();
        test_random_stream(1'b0, 1'b0, 145);
        test_random_stream(1'b1, 1'b0, 145);
        test_random_stream(1'b1, 1'b1, 145);
        test_random_stream(1'b0, 1'b1, 145);
        test_stall_until_empty();

        wait_empty();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ibf_pkg.sv
rtl/ibf_decode.sv
rtl/ibf_normalize.sv
rtl/ibf_pack.sv
rtl/ibm_ieee_float_converter.sv
tb/ibm_ieee_float_converter_tb.sv
